>>> src/mrx_pkg.sv
// ----------------------------------------------------------------------------
// mrx_pkg: shared types and constants for the MIPS R-type execute core
// Function codes, status codes and the request and status words of the multiply/divide unit.
// ----------------------------------------------------------------------------
package mrx_pkg;

  localparam int unsigned XLEN      = 32;
  localparam int unsigned REG_AW    = 5;
  localparam int unsigned NUM_REGS  = 32;
  localparam int unsigned STATUS_W  = 3;

  localparam logic [5:0] OP_RTYPE   = 6'h00;

  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_DIV     = 6'h1A;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2A;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_HALT    = 3'd1;
  localparam logic [2:0] ST_BADFN   = 3'd2;
  localparam logic [2:0] ST_BADOP   = 3'd3;
  localparam logic [2:0] ST_DIVZ    = 3'd4;

  // Start request to the iterative multiply/divide unit.
  typedef struct packed {
    logic start;
    logic is_div;
  } md_req_t;

  // Completion report from the multiply/divide unit.
  typedef struct packed {
    logic busy;
    logic done;
  } md_stat_t;

endpackage

>>> src/mrx_if.sv
// ----------------------------------------------------------------------------
// mrx_if: handshake channels for the execute core
// Instruction channel and result channel, each valid/ready with payload.
// ----------------------------------------------------------------------------
interface mrx_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;
  modport source (output valid, output instr_word, input ready);
  modport sink   (input valid, input instr_word, output ready);
endinterface

interface mrx_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        wrote_reg;
  logic [4:0]  dest_reg;
  logic [31:0] dest_value;
  logic [31:0] next_pc;
  modport source (output valid, output status, output wrote_reg, output dest_reg,
                  output dest_value, output next_pc, input ready);
  modport sink   (input valid, input status, input wrote_reg, input dest_reg,
                  input dest_value, input next_pc, output ready);
endinterface

>>> src/mrx_regfile.sv
// ----------------------------------------------------------------------------
// mrx_regfile: general register file
// Two synchronous (registered) read ports and one write port.
// Entries carry valid bits so that reset reads back as zero at once.
// ----------------------------------------------------------------------------
module mrx_regfile (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [mrx_pkg::REG_AW-1:0]    raddr_a,
  input  logic [mrx_pkg::REG_AW-1:0]    raddr_b,
  output logic [mrx_pkg::XLEN-1:0]      rdata_a,
  output logic [mrx_pkg::XLEN-1:0]      rdata_b,
  input  logic                          we,
  input  logic [mrx_pkg::REG_AW-1:0]    waddr,
  input  logic [mrx_pkg::XLEN-1:0]      wdata
);
  logic [mrx_pkg::XLEN-1:0]     mem [mrx_pkg::NUM_REGS];
  logic [mrx_pkg::NUM_REGS-1:0] vld;
  logic [mrx_pkg::XLEN-1:0]     qa, qb;
  logic                         va, vb;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    qa <= mem[raddr_a];
    qb <= mem[raddr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      va  <= 1'b0;
      vb  <= 1'b0;
    end else begin
      if (we && waddr != '0) begin
        vld[waddr] <= 1'b1;
      end
      va <= vld[raddr_a];
      vb <= vld[raddr_b];
    end
  end

  assign rdata_a = va ? qa : '0;
  assign rdata_b = vb ? qb : '0;
endmodule

>>> src/mrx_muldiv.sv
// ----------------------------------------------------------------------------
// mrx_muldiv: iterative signed multiply and divide
// One bit per cycle; results for HI and LO.
// ----------------------------------------------------------------------------
module mrx_muldiv (
  input  logic                     clk,
  input  logic                     rst,
  input  mrx_pkg::md_req_t         req,
  input  logic [mrx_pkg::XLEN-1:0] op_a,
  input  logic [mrx_pkg::XLEN-1:0] op_b,
  output mrx_pkg::md_stat_t        stat,
  output logic [mrx_pkg::XLEN-1:0] hi,
  output logic [mrx_pkg::XLEN-1:0] lo
);
  localparam int unsigned W = mrx_pkg::XLEN;

  logic          busy, is_div, neg_q, neg_r, done;
  logic [5:0]    cnt;
  logic [W-1:0]  acc, quo, dsr;
  logic [W:0]    trial;
  logic [W-1:0]  abs_a, abs_b;
  logic [W:0]    psum;

  assign abs_a = op_a[W-1] ? (~op_a + 1'b1) : op_a;
  assign abs_b = op_b[W-1] ? (~op_b + 1'b1) : op_b;
  assign trial = {acc, quo[W-1]} - {1'b0, dsr};
  assign psum  = {1'b0, acc} + (quo[0] ? {1'b0, dsr} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        is_div <= req.is_div;
        cnt    <= 6'(W);
        acc    <= '0;
        quo    <= abs_a;
        dsr    <= abs_b;
        neg_q  <= op_a[W-1] ^ op_b[W-1];
        neg_r  <= op_a[W-1];
      end else if (busy) begin
        if (is_div) begin
          if (!trial[W]) begin
            acc <= trial[W-1:0];
            quo <= {quo[W-2:0], 1'b1};
          end else begin
            acc <= {acc[W-2:0], quo[W-1]};
            quo <= {quo[W-2:0], 1'b0};
          end
        end else begin
          acc <= psum[W:1];
          quo <= {psum[0], quo[W-1:1]};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Sign fix-up of magnitudes after the last step.
  logic [2*W-1:0] prod, prod_s;
  assign prod   = {acc, quo};
  assign prod_s = neg_q ? (~prod + 1'b1) : prod;

  always_comb begin
    if (is_div) begin
      lo = neg_q ? (~quo + 1'b1) : quo;
      hi = neg_r ? (~acc + 1'b1) : acc;
    end else begin
      lo = prod_s[W-1:0];
      hi = prod_s[2*W-1:W];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> $past(busy)) else $error("done without busy");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy) else $error("start while busy");
  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> !busy) else $error("busy at done");
`endif
endmodule

>>> src/mips_rtype_execute_core.sv
// ----------------------------------------------------------------------------
// mips_rtype_execute_core: MIPS32 R-type execute stage
// Decodes one instruction word, executes it against the register file,
// HI/LO and PC, and returns status, register write and next PC.
// ----------------------------------------------------------------------------
// Usage. Instruction words arrive on the in channel and one result word
// leaves on the out channel for each of them. The block works on one
// instruction at a time. An instruction is accepted, then the register file
// is read (synchronous memory), then executed. Simple operations pass
// through S_READ and S_EXEC into the output register; a new word is taken
// only after the result has been taken. MULT and DIV with a nonzero divisor
// run on the shared bit-serial unit, one bit per cycle, and pass through
// S_READ and S_MD into the output register. The result sits in an output
// register; while the receiver stalls, the block holds it and accepts no
// further instruction, since the next instruction may read what this one
// wrote.
// Reset clears the PC, HI and LO, and the register-file valid bits so all
// registers read as zero immediately; no clearing pass is needed.
// Register zero is never written. Errors and SYSCALL leave all state alone
// and repeat the current PC; a zero divisor reports and advances the PC.
// ----------------------------------------------------------------------------
module mips_rtype_execute_core (
  input logic    clk,
  input logic    rst,
  mrx_in_if.sink   in_ch,
  mrx_out_if.source out_ch
);
  localparam int unsigned W = mrx_pkg::XLEN;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_EXEC = 5'b00100,
    S_MD   = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [31:0] instr;
  logic [W-1:0] pc, hi_reg, lo_reg;
  logic [W-1:0] a, b;

  logic [5:0] op, fn;
  logic [4:0] rd, sh;
  assign op = instr[31:26];
  assign rd = instr[15:11];
  assign sh = instr[10:6];
  assign fn = instr[5:0];

  // Register file reads are addressed straight from the incoming word.
  logic rf_we;
  logic [4:0] rf_waddr;
  logic [W-1:0] rf_wdata;

  mrx_regfile u_rf (
    .clk(clk), .rst(rst),
    .raddr_a(in_ch.instr_word[25:21]), .raddr_b(in_ch.instr_word[20:16]),
    .rdata_a(a), .rdata_b(b),
    .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata)
  );

  mrx_pkg::md_req_t  md_req;
  mrx_pkg::md_stat_t md_stat;
  logic [W-1:0] md_hi, md_lo;

  mrx_muldiv u_md (
    .clk(clk), .rst(rst), .req(md_req), .op_a(a), .op_b(b),
    .stat(md_stat), .hi(md_hi), .lo(md_lo)
  );

  // Operands are held in the register-file output only for the read cycle,
  // so they are captured at S_READ.
  logic [W-1:0] ra, rb;

  // Execute decode.
  logic [2:0]   ex_status;
  logic         ex_wr;
  logic [W-1:0] ex_val, ex_npc;

  always_comb begin
    ex_status = mrx_pkg::ST_OK;
    ex_wr     = 1'b0;
    ex_val    = '0;
    ex_npc    = pc + 32'd4;
    if (op != mrx_pkg::OP_RTYPE) begin
      ex_status = mrx_pkg::ST_BADOP;
      ex_npc    = pc;
    end else begin
      case (fn)
        mrx_pkg::FN_ADD:  begin ex_wr = 1'b1; ex_val = ra + rb; end
        mrx_pkg::FN_SUB:  begin ex_wr = 1'b1; ex_val = ra - rb; end
        mrx_pkg::FN_AND:  begin ex_wr = 1'b1; ex_val = ra & rb; end
        mrx_pkg::FN_OR:   begin ex_wr = 1'b1; ex_val = ra | rb; end
        mrx_pkg::FN_XOR:  begin ex_wr = 1'b1; ex_val = ra ^ rb; end
        mrx_pkg::FN_NOR:  begin ex_wr = 1'b1; ex_val = ~(ra | rb); end
        mrx_pkg::FN_SLT:  begin
          ex_wr  = 1'b1;
          ex_val = {31'd0, ($signed(ra) < $signed(rb))};
        end
        mrx_pkg::FN_SLL:  begin ex_wr = 1'b1; ex_val = rb << sh; end
        mrx_pkg::FN_SRL:  begin ex_wr = 1'b1; ex_val = rb >> sh; end
        mrx_pkg::FN_SRA:  begin ex_wr = 1'b1; ex_val = $unsigned($signed(rb) >>> sh); end
        mrx_pkg::FN_MFHI: begin ex_wr = 1'b1; ex_val = hi_reg; end
        mrx_pkg::FN_MFLO: begin ex_wr = 1'b1; ex_val = lo_reg; end
        mrx_pkg::FN_JR:   ex_npc = ra;
        mrx_pkg::FN_MULT: ex_status = mrx_pkg::ST_OK;
        mrx_pkg::FN_DIV:  begin
          if (rb == '0) ex_status = mrx_pkg::ST_DIVZ;
        end
        mrx_pkg::FN_SYSCALL: begin ex_status = mrx_pkg::ST_HALT; ex_npc = pc; end
        default:          begin ex_status = mrx_pkg::ST_BADFN; ex_npc = pc; end
      endcase
    end
    if (ex_wr && rd == '0) begin
      ex_wr  = 1'b0;
      ex_val = '0;
    end
  end

  // The multiply/divide unit starts from the register-file outputs, which are
  // still valid in S_READ; the decision is taken there from the captured word.
  logic rd_is_md;
  assign rd_is_md = (op == mrx_pkg::OP_RTYPE) &&
                    ((fn == mrx_pkg::FN_MULT) || (fn == mrx_pkg::FN_DIV && b != '0));

  assign md_req.start  = (state == S_READ) && rd_is_md;
  assign md_req.is_div = (fn == mrx_pkg::FN_DIV);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_ch.valid) state_next = S_READ;
      S_READ: state_next = rd_is_md ? S_MD : S_EXEC;
      S_EXEC: state_next = S_OUT;
      S_MD:   if (md_stat.done) state_next = S_OUT;
      S_OUT:  if (out_ch.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ch.ready  = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);

  assign rf_we    = (state == S_EXEC) && ex_wr;
  assign rf_waddr = rd;
  assign rf_wdata = ex_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pc     <= '0;
      hi_reg <= '0;
      lo_reg <= '0;
    end else begin
      state <= state_next;
      if (state == S_EXEC) begin
        pc <= ex_npc;
      end
      if (state == S_MD && md_stat.done) begin
        pc     <= pc + 32'd4;
        hi_reg <= md_hi;
        lo_reg <= md_lo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      instr <= in_ch.instr_word;
    end
    if (state == S_READ) begin
      ra <= a;
      rb <= b;
    end
    if (state == S_EXEC) begin
      out_ch.status     <= ex_status;
      out_ch.wrote_reg  <= ex_wr;
      out_ch.dest_reg   <= ex_wr ? rd : '0;
      out_ch.dest_value <= ex_val;
      out_ch.next_pc    <= ex_npc;
    end
    if (state == S_MD && md_stat.done) begin
      out_ch.status     <= mrx_pkg::ST_OK;
      out_ch.wrote_reg  <= 1'b0;
      out_ch.dest_reg   <= '0;
      out_ch.dest_value <= '0;
      out_ch.next_pc    <= pc + 32'd4;
    end
  end

`ifndef SYNTHESIS
  a_no_zero_write: assert property (@(posedge clk) disable iff (rst)
    rf_we |-> rf_waddr != '0) else $error("write to register zero");
  a_md_only_in_read: assert property (@(posedge clk) disable iff (rst)
    md_req.start |=> state == S_MD) else $error("multiply/divide start misplaced");
  a_out_held: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid) else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready) else $error("accept while result pending");
`endif
endmodule

>>> dv/mips_rtype_execute_core_test.sv
// ----------------------------------------------------------------------------
// mips_rtype_execute_core_test: self-checking bench for the R-type execute core
// Streams directed and random instruction words through the core, predicts
// every result word from its own architectural state and compares them.
// ----------------------------------------------------------------------------

class exec_scoreboard;
  logic [31:0] regs [32];
  logic [31:0] hi_val, lo_val, pc_val;
  logic [2:0]  pend_status[$];
  logic        pend_wr[$];
  logic [4:0]  pend_rd[$];
  logic [31:0] pend_val[$];
  logic [31:0] pend_pc[$];
  int          errors;
  int          checked;

  function void clear();
    foreach (regs[i]) regs[i] = '0;
    hi_val = '0;
    lo_val = '0;
    pc_val = '0;
    errors = 0;
    checked = 0;
  endfunction

  function int pending();
    return pend_status.size();
  endfunction

  // Executes one accepted word on the shadow state and queues its outcome.
  function void note_instr(logic [31:0] w);
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sh;
    logic [31:0] a, b, val, npc;
    logic [2:0]  st;
    logic        wr;
    logic signed [63:0] prod, qa, qb;
    op = w[31:26]; rs = w[25:21]; rt = w[20:16];
    rd = w[15:11]; sh = w[10:6]; fn = w[5:0];
    a = regs[rs]; b = regs[rt];
    st = mrx_pkg::ST_OK; wr = 1'b0; val = '0; npc = pc_val + 32'd4;
    if (op != mrx_pkg::OP_RTYPE) begin
      st = mrx_pkg::ST_BADOP;
      npc = pc_val;
    end else begin
      case (fn)
        mrx_pkg::FN_ADD: begin wr = 1'b1; val = a + b; end
        mrx_pkg::FN_SUB: begin wr = 1'b1; val = a - b; end
        mrx_pkg::FN_AND: begin wr = 1'b1; val = a & b; end
        mrx_pkg::FN_OR: begin wr = 1'b1; val = a | b; end
        mrx_pkg::FN_XOR: begin wr = 1'b1; val = a ^ b; end
        mrx_pkg::FN_NOR: begin wr = 1'b1; val = ~(a | b); end
        mrx_pkg::FN_SLT: begin
          wr = 1'b1;
          val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
        end
        mrx_pkg::FN_SLL: begin wr = 1'b1; val = b << sh; end
        mrx_pkg::FN_SRL: begin wr = 1'b1; val = b >> sh; end
        mrx_pkg::FN_SRA: begin wr = 1'b1; val = $signed(b) >>> sh; end
        mrx_pkg::FN_MFHI: begin wr = 1'b1; val = hi_val; end
        mrx_pkg::FN_MFLO: begin wr = 1'b1; val = lo_val; end
        mrx_pkg::FN_JR: npc = a;
        mrx_pkg::FN_MULT: begin
          prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
          lo_val = prod[31:0];
          hi_val = prod[63:32];
        end
        mrx_pkg::FN_DIV: begin
          if (b == '0) begin
            st = mrx_pkg::ST_DIVZ;
          end else begin
            qa = $signed({{32{a[31]}}, a});
            qb = $signed({{32{b[31]}}, b});
            lo_val = 32'(qa / qb);
            hi_val = 32'(qa % qb);
          end
        end
        mrx_pkg::FN_SYSCALL: begin
          st = mrx_pkg::ST_HALT;
          npc = pc_val;
        end
        default: begin
          st = mrx_pkg::ST_BADFN;
          npc = pc_val;
        end
      endcase
    end
    // Writes to register zero vanish and leave a blank write report.
    if (wr && rd == '0) begin
      wr = 1'b0;
      val = '0;
    end
    if (wr) regs[rd] = val;
    pc_val = npc;
    pend_status.push_back(st);
    pend_wr.push_back(wr);
    pend_rd.push_back(wr ? rd : 5'd0);
    pend_val.push_back(val);
    pend_pc.push_back(npc);
  endfunction

  function void check_result(logic [2:0] st, logic wr, logic [4:0] rd,
                             logic [31:0] val, logic [31:0] npc);
    logic [2:0]  e_st;
    logic        e_wr;
    logic [4:0]  e_rd;
    logic [31:0] e_val, e_pc;
    if (pend_status.size() == 0) begin
      $display("%0t: unexpected result word status=%0d pc=%h", $time, st, npc);
      errors++;
      return;
    end
    e_st = pend_status.pop_front();
    e_wr = pend_wr.pop_front();
    e_rd = pend_rd.pop_front();
    e_val = pend_val.pop_front();
    e_pc = pend_pc.pop_front();
    checked++;
    if (st !== e_st) begin
      $display("%0t: status expected %0d actual %0d", $time, e_st, st); errors++;
    end
    if (wr !== e_wr) begin
      $display("%0t: wrote_reg expected %0d actual %0d", $time, e_wr, wr); errors++;
    end
    if (rd !== e_rd) begin
      $display("%0t: dest_reg expected %0d actual %0d", $time, e_rd, rd); errors++;
    end
    if (val !== e_val) begin
      $display("%0t: dest_value expected %h actual %h", $time, e_val, val); errors++;
    end
    if (npc !== e_pc) begin
      $display("%0t: next_pc expected %h actual %h", $time, e_pc, npc); errors++;
    end
  endfunction
endclass

module mips_rtype_execute_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_WORDS   = 320;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mrx_in_if  in_ch ();
  mrx_out_if out_ch ();

  mips_rtype_execute_core uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  exec_scoreboard sb;

  // Idle percentages for the sender and the receiver; the stimulus process
  // steps them through the phases.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  // While set, the receiver holds ready low.
  logic hold_off_req = 1'b0;
  logic stim_done = 1'b0;
  int   quiet_cycles = 0;

  // The list of functions the random part draws from.
  logic [5:0] fn_list [16] = '{
    mrx_pkg::FN_SLL, mrx_pkg::FN_SRL, mrx_pkg::FN_SRA, mrx_pkg::FN_JR,
    mrx_pkg::FN_SYSCALL, mrx_pkg::FN_MFHI, mrx_pkg::FN_MFLO, mrx_pkg::FN_MULT,
    mrx_pkg::FN_DIV, mrx_pkg::FN_ADD, mrx_pkg::FN_SUB, mrx_pkg::FN_AND,
    mrx_pkg::FN_OR, mrx_pkg::FN_XOR, mrx_pkg::FN_NOR, mrx_pkg::FN_SLT};

  initial begin
    in_ch.valid = 1'b0;
    in_ch.instr_word = '0;
    out_ch.ready = 1'b0;
  end

  // Accepted words are noted on the rising edge, which is where the core
  // sees the handshake as well. Sampling there, before the falling-edge
  // drivers move anything, keeps the result independent of event order.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) sb.note_instr(in_ch.instr_word);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.status, out_ch.wrote_reg, out_ch.dest_reg,
                        out_ch.dest_value, out_ch.next_pc);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: stalls at random, or for a long stretch on request.
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off_req) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offers one word and holds it until it is taken. Valid is lowered after
  // the word is taken and raised again at a later falling edge, so it never
  // gets two updates in one step.
  task automatic send_word(logic [31:0] w);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.instr_word <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  function automatic logic [31:0] rtype(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                        logic [4:0] sh, logic [5:0] fn);
    return {mrx_pkg::OP_RTYPE, rs, rt, rd, sh, fn};
  endfunction

  // Operand values that stress the arithmetic: the signed extremes, all
  // ones, one and zero, or else a random value.
  function automatic logic [31:0] edge_operand();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0001;
      4: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Registers can only be loaded by arithmetic, so a value is built from
  // SLL/OR on a register known to hold one. Register 1 is kept at one and
  // register 2 is scratch; the loaded value lands in rd.
  task automatic load_reg(logic [4:0] rd, logic [31:0] v);
    send_word(rtype(5'd0, 5'd1, 5'd2, 5'd0, mrx_pkg::FN_SLL));
    send_word(rtype(5'd0, 5'd0, rd, 5'd0, mrx_pkg::FN_OR));
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        send_word(rtype(5'd0, 5'd1, 5'd2, 5'(i), mrx_pkg::FN_SLL));
        send_word(rtype(rd, 5'd2, rd, 5'd0, mrx_pkg::FN_OR));
      end
    end
  endtask

  // A random word: mostly well-formed R-type work on random registers,
  // with some R-type words of random function and some foreign opcodes.
  function automatic logic [31:0] random_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(19))
      0: begin
        if (w[31:26] == mrx_pkg::OP_RTYPE) w[26] = 1'b1;
      end
      1: begin
        w[31:26] = mrx_pkg::OP_RTYPE;
        if (w[15:11] == 5'd1) w[15:11] = 5'd3 + 5'($urandom_range(28));
      end
      default: begin
        w[31:26] = mrx_pkg::OP_RTYPE;
        w[5:0] = fn_list[$urandom_range(15)];
        // Keep register 1 at one for the value loader.
        if (w[15:11] == 5'd1) w[15:11] = 5'd3 + 5'($urandom_range(28));
      end
    endcase
    return w;
  endfunction

  task automatic drain();
    while (sb.pending() != 0) @(negedge clk);
  endtask

  int sent;

  initial begin
    sb = new();
    sb.clear();
    sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: register 1 becomes one (NOR of zeros, then SLT of -1).
    send_word(rtype(5'd0, 5'd0, 5'd5, 5'd0, mrx_pkg::FN_NOR));
    send_word(rtype(5'd5, 5'd0, 5'd1, 5'd0, mrx_pkg::FN_SLT));
    load_reg(5'd6, 32'h8000_0000);
    send_word(rtype(5'd0, 5'd5, 5'd7, 5'd0, mrx_pkg::FN_SUB));    // 7 = 1
    send_word(rtype(5'd6, 5'd5, 5'd0, 5'd0, mrx_pkg::FN_DIV));    // overflow case
    send_word(rtype(5'd0, 5'd0, 5'd8, 5'd0, mrx_pkg::FN_MFHI));
    send_word(rtype(5'd0, 5'd0, 5'd9, 5'd0, mrx_pkg::FN_MFLO));
    send_word(rtype(5'd6, 5'd0, 5'd0, 5'd0, mrx_pkg::FN_DIV));    // divide by zero
    send_word(rtype(5'd6, 5'd6, 5'd0, 5'd0, mrx_pkg::FN_MULT));
    send_word(rtype(5'd0, 5'd0, 5'd10, 5'd0, mrx_pkg::FN_MFHI));
    send_word(rtype(5'd0, 5'd6, 5'd11, 5'd31, mrx_pkg::FN_SRA));
    send_word(rtype(5'd0, 5'd5, 5'd12, 5'd31, mrx_pkg::FN_SRL));
    send_word(rtype(5'd6, 5'd5, 5'd0, 5'd0, mrx_pkg::FN_ADD));    // write to zero
    send_word(rtype(5'd5, 5'd6, 5'd13, 5'd0, mrx_pkg::FN_XOR));
    send_word(rtype(5'd5, 5'd6, 5'd14, 5'd0, mrx_pkg::FN_AND));
    send_word(32'hFFFF_FFFF);                                     // foreign opcode
    send_word(rtype(5'd0, 5'd0, 5'd0, 5'd0, 6'h3F));              // bad function
    send_word(rtype(5'd0, 5'd0, 5'd0, 5'd0, mrx_pkg::FN_SYSCALL));
    send_word(rtype(5'd6, 5'd0, 5'd0, 5'd0, mrx_pkg::FN_JR));
    drain();

    // Random part across the idle phases. Before each phase one register is
    // loaded with an operand from edge_operand so that it feeds the random work.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      load_reg(5'd3 + 5'($urandom_range(28)), edge_operand());
      for (int i = 0; i < RANDOM_WORDS / 4; i++) begin
        send_word(random_word());
        sent++;
        if (i == 20 && phase == 2) begin
          // Long receiver hold-off while words keep being offered, so the
          // core fills and stops taking input.
          hold_off_req <= 1'b1;
          fork
            begin
              repeat (150) @(negedge clk);
              hold_off_req <= 1'b0;
            end
          join_none
        end
      end
      // The sender pauses until every expected result word has arrived.
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    repeat (50) @(negedge clk);
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done || quiet_cycles >= WATCHDOG_LIMIT);
    if (!stim_done) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("mips_rtype_execute_core_test: done, errors");
      $finish;
    end else begin
      $display("Covered %0d random words plus directed extremes; %0d result words checked.",
               sent, sb.checked);
      if (sb.errors == 0 && sb.pending() == 0)
        $display("mips_rtype_execute_core_test: done, clean");
      else
        $display("mips_rtype_execute_core_test: done, errors");
      $finish;
    end
  end

endmodule

>>> filelist.f
src/mrx_pkg.sv
src/mrx_if.sv
src/mrx_regfile.sv
src/mrx_muldiv.sv
src/mips_rtype_execute_core.sv
dv/mips_rtype_execute_core_test.sv
